@@ design/rpn_pkg.sv @@
// package: types, codes and sizes for the rpn stack evaluator
`default_nettype none
package rpn_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    localparam logic [1:0] OPN_PUSH = 2'd0;
    localparam logic [1:0] OPN_APPLY = 2'd1;
    localparam logic [1:0] OPN_FINISH = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [30:0] number;
        logic [2:0]  operator_code;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_item_t;

    typedef struct packed {
        logic        go;
        logic [2:0]  op;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } alu_req_t;
endpackage
`default_nettype wire

@@ design/rpn_alu.sv @@
// iterative arithmetic unit: add, subtract, multiply, divide, power
`default_nettype none
module rpn_alu
    import rpn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire alu_req_t    req,
    output logic             done,
    output logic [31:0]      result
);
    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_DIV  = 4'b0010,
        A_POW  = 4'b0100,
        A_FIN  = 4'b1000
    } astate_t;

    astate_t state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] expo_reg, expo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        phase_reg, phase_next;
    logic [31:0] mul_a, mul_b, mul_p;
    logic [32:0] trial;
    logic [31:0] ma, mb;

    // one shared 32x32 low-half multiplier
    assign mul_p = mul_a * mul_b;
    assign ma = req.lhs[31] ? (32'd0 - req.lhs) : req.lhs;
    assign mb = req.rhs[31] ? (32'd0 - req.rhs) : req.rhs;
    assign trial = {rem_reg, acc_reg[31]} - {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        acc_next = acc_reg;
        base_next = base_reg;
        expo_next = expo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        phase_next = phase_reg;
        mul_a = req.lhs;
        mul_b = req.rhs;
        done = 1'b0;
        result = acc_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.go)
                begin
                    case (req.op)
                        OP_ADD:
                        begin
                            acc_next = req.lhs + req.rhs;
                            state_next = A_FIN;
                        end
                        OP_SUB:
                        begin
                            acc_next = req.lhs - req.rhs;
                            state_next = A_FIN;
                        end
                        OP_MUL:
                        begin
                            acc_next = mul_p;
                            state_next = A_FIN;
                        end
                        OP_DIV:
                        begin
                            acc_next = ma;
                            rem_next = 32'd0;
                            div_next = mb;
                            neg_next = req.lhs[31] ^ req.rhs[31];
                            cnt_next = 6'd0;
                            state_next = A_DIV;
                        end
                        default:
                        begin
                            if (req.rhs[31])
                            begin
                                if (req.lhs == 32'd1)
                                    acc_next = 32'd1;
                                else if (req.lhs == 32'hFFFF_FFFF)
                                    acc_next = req.rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                                else
                                    acc_next = 32'd0;
                                state_next = A_FIN;
                            end
                            else
                            begin
                                acc_next = 32'd1;
                                base_next = req.lhs;
                                expo_next = req.rhs;
                                phase_next = 1'b0;
                                state_next = A_POW;
                            end
                        end
                    endcase
                end
            end
            A_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    acc_next = {acc_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], acc_reg[31]};
                    acc_next = {acc_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = A_FIN;
            end
            A_POW:
            begin
                // even phase: multiply acc by base when the low exponent bit is set, odd phase: square base
                if (expo_reg == 32'd0)
                begin
                    neg_next = 1'b0;
                    state_next = A_FIN;
                end
                else if (!phase_reg)
                begin
                    mul_a = acc_reg;
                    mul_b = base_reg;
                    if (expo_reg[0])
                        acc_next = mul_p;
                    phase_next = 1'b1;
                end
                else
                begin
                    mul_a = base_reg;
                    mul_b = base_reg;
                    base_next = mul_p;
                    expo_next = {1'b0, expo_reg[31:1]};
                    phase_next = 1'b0;
                end
            end
            A_FIN:
            begin
                done = 1'b1;
                result = neg_reg ? (32'd0 - acc_reg) : acc_reg;
                neg_next = 1'b0;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            neg_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        base_reg <= base_next;
        expo_reg <= expo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        phase_reg <= phase_next;
    end
endmodule
`default_nettype wire

@@ design/rpn_stack_evaluator_core.sv @@
// top level: operand stack, sequencer and shared arithmetic unit
// an apply reads the top two entries (S_RD1, S_RD2), runs the arithmetic unit
// (S_ALU, S_WAIT) and writes back; power is done by square and multiply
// one item at a time; busy is high while an apply or a non-empty finish is at work
// the result strobe is registered, set from S_FIN or from S_IDLE when empty; no stall
// reset clears stack pointer, error code and control; stack contents are
// left undefined
`default_nettype none
module rpn_stack_evaluator_core
    import rpn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire in_item_t  item,
    output logic           busy,
    output logic           result_valid,
    output out_item_t      result
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD1   = 6'b000010,
        S_RD2   = 6'b000100,
        S_ALU   = 6'b001000,
        S_WAIT  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [2:0] err_reg, err_next;
    in_item_t item_reg;
    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_reg;
    logic [31:0] rhs_reg, rhs_next;
    logic [IDX_W-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0] wr_data;
    logic [SP_W-1:0] sp_m1, sp_m2;
    alu_req_t alu_req;
    logic alu_done;
    logic [31:0] alu_res;
    logic outv_reg, outv_next;
    out_item_t out_reg, out_next;

    assign sp_m1 = sp_reg - SP_W'(1);
    assign sp_m2 = sp_reg - SP_W'(2);

    rpn_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .done   (alu_done),
        .result (alu_res)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
        if (start && !busy)
            item_reg <= item;
        rhs_reg <= rhs_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        err_next = err_reg;
        rhs_next = rhs_reg;
        rd_en = 1'b0;
        rd_addr = sp_m1[IDX_W-1:0];
        wr_en = 1'b0;
        wr_addr = sp_reg[IDX_W-1:0];
        wr_data = {1'b0, item.number};
        alu_req = '{go: 1'b0, op: item_reg.operator_code, lhs: rd_reg, rhs: rhs_reg};
        outv_next = 1'b0;
        out_next = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.operation)
                        OPN_PUSH:
                        begin
                            if (sp_reg >= SP_W'(STACK_DEPTH))
                            begin
                                if (err_reg == ST_OK)
                                    err_next = ST_OVER;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                sp_next = sp_reg + SP_W'(1);
                            end
                        end
                        OPN_APPLY:
                        begin
                            if (item.operator_code <= OP_POW)
                            begin
                                if (sp_reg < SP_W'(2))
                                begin
                                    if (err_reg == ST_OK)
                                        err_next = ST_UNDER;
                                end
                                else
                                begin
                                    rd_en = 1'b1;
                                    state_next = S_RD1;
                                end
                            end
                        end
                        OPN_FINISH:
                        begin
                            if (sp_reg == '0)
                            begin
                                out_next.value = '0;
                                out_next.status = (err_reg == ST_OK) ? ST_EMPTY : err_reg;
                                err_next = ST_OK;
                                outv_next = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                sp_next = sp_m1;
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD1:
            begin
                // top is in rd_reg now; keep it and fetch the entry below it
                rhs_next = rd_reg;
                rd_en = 1'b1;
                rd_addr = sp_m2[IDX_W-1:0];
                state_next = S_RD2;
            end
            S_RD2:
            begin
                state_next = S_ALU;
            end
            S_ALU:
            begin
                if (item_reg.operator_code == OP_DIV && rhs_reg == 32'd0)
                begin
                    if (err_reg == ST_OK)
                        err_next = ST_DIVZERO;
                    state_next = S_IDLE;
                end
                else
                begin
                    alu_req.go = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (alu_done)
                begin
                    wr_en = 1'b1;
                    wr_addr = sp_m2[IDX_W-1:0];
                    wr_data = alu_res;
                    sp_next = sp_m1;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                out_next.value = rd_reg;
                out_next.status = err_reg;
                err_next = ST_OK;
                outv_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = outv_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            err_reg <= ST_OK;
            outv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            err_reg <= err_next;
            outv_reg <= outv_next;
        end
    end
endmodule
`default_nettype wire
